// ----- rtl/tbsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tbsc_pkg
// Shared types, constants and helper functions for the byte stream cipher.
// ----------------------------------------------------------------------------
package tbsc_pkg;

  localparam logic [31:0] SEED_H = 32'h95DE1432;
  localparam logic [31:0] MUL_H  = 32'hA8657C5B;
  localparam logic [31:0] SEED_K = 32'h2F63BE6A;
  localparam logic [31:0] SEED_C = 32'h8462E35C;

  localparam int unsigned TBL_DEPTH = 256;
  localparam int unsigned TBL_AW    = 8;
  localparam int unsigned KEY_REGS  = 4;
  localparam int unsigned KEY_BYTES = 32;
  localparam int unsigned KEY_IW    = 2;
  localparam int unsigned KEY_SW    = 5;

  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_ENC     = 2'd1;
  localparam logic [1:0] ACT_DEC     = 2'd2;

  localparam logic [TBL_AW-1:0] LAST_PRE  = TBL_AW'(KEY_BYTES - 1);
  localparam logic [TBL_AW-1:0] LAST_FILL = TBL_AW'(TBL_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED_PRE,
    ST_SCHED_FILL,
    ST_READ,
    ST_MIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              en;
    logic [KEY_IW-1:0] idx;
    logic [63:0]       data;
  } cfg_wr_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [31:0]       data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
  } tbl_rd_t;

  function automatic logic [31:0] stir(input logic [31:0] x);
    return (x << 2) ^ (x >> 2);
  endfunction

  function automatic logic [7:0] fold(input logic [31:0] x);
    return x[31:24] ^ x[23:16] ^ x[15:8] ^ x[7:0];
  endfunction

endpackage

// ----- rtl/tbsc_ram.sv -----
// ----------------------------------------------------------------------------
// tbsc_ram
// Mixing table: 256 x 32 bit, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tbsc_ram
  import tbsc_pkg::*;
(
  input  logic        clk,
  input  tbl_wr_t     wr,
  input  tbl_rd_t     rd,
  output logic [31:0] rdata
);

  logic [31:0] mem [TBL_DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tbsc_key.sv -----
// ----------------------------------------------------------------------------
// tbsc_key
// Key registers and the key term: signed key byte plus schedule index.
// ----------------------------------------------------------------------------
module tbsc_key
  import tbsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_wr_t           wr,
  input  logic [KEY_SW-1:0] sel,
  input  logic [TBL_AW-1:0] add,
  output logic [31:0]       term
);

  logic [63:0] key_r [KEY_REGS];
  logic [7:0]  kb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) begin
        key_r[i] <= '0;
      end
    end else if (wr.en) begin
      key_r[wr.idx] <= wr.data;
    end
  end

  assign kb   = key_r[sel[KEY_SW-1:3]][{sel[2:0], 3'b000} +: 8];
  assign term = {{24{kb[7]}}, kb} + {{(32-TBL_AW){1'b0}}, add};

endmodule

// ----- rtl/table_driven_byte_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// table_driven_byte_stream_cipher
// Byte stream cipher around a 256-word mixing table in block RAM.
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  in_     | in        | action, data_in
//  out_    | out       | data_out, restart_done
//  cfg_    | in        | index, data (key register write, always ready)
//
//  Encipher/decipher: each byte takes two dependent table reads (position
//  read, then feedback read) plus the table write, then the mix step.
//  Restart: key schedule of 32 warm-up steps and 256 table writes, one
//  multiply-xor step per cycle, then ST_OUT posts the result.
//  Input is taken only in idle; a held output beat stalls the final cycle.
//  Reset clears key registers, mixing word and counter; the table is not
//  cleared and must be filled by a restart before use.
// ----------------------------------------------------------------------------
module table_driven_byte_stream_cipher
  import tbsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_out,
  output logic        out_restart_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [TBL_AW-1:0] step_r, step_nxt;
  logic [31:0]       h_r, h_nxt;
  logic [31:0]       mw_r, mw_nxt;
  logic [31:0]       cnt_r, cnt_nxt;
  logic [1:0]        act_r;
  logic [7:0]        data_r;
  logic [7:0]        pos_r;
  logic [7:0]        res_r;
  logic              fwd_r;
  logic [31:0]       new_r;
  logic              out_valid_r;
  logic [7:0]        out_data_r;
  logic              out_rd_r;

  cfg_wr_t     cfg_wr;
  tbl_wr_t     tbl_wr;
  tbl_rd_t     tbl_rd;
  logic [31:0] tbl_rdata;
  logic [31:0] term;

  logic        accept;
  logic        slot_free;
  logic [31:0] prod_h, prod_k, prod_c;
  logic [31:0] old_new;
  logic [7:0]  res_now;
  logic [7:0]  plain;
  logic [7:0]  idx2;
  logic [31:0] fb_word;
  logic        ld_out, ld_restart;
  logic        ld_pre, ld_fill, ld_item, ld_read, ld_mix;

  assign cfg_ready  = 1'b1;
  assign cfg_wr.en   = cfg_valid;
  assign cfg_wr.idx  = cfg_index;
  assign cfg_wr.data = cfg_data;

  tbsc_key u_key (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (cfg_wr),
    .sel  (step_r[KEY_SW-1:0]),
    .add  (step_r),
    .term (term)
  );

  tbsc_ram u_ram (
    .clk  (clk),
    .wr   (tbl_wr),
    .rd   (tbl_rd),
    .rdata(tbl_rdata)
  );

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign prod_h = MUL_H * term;
  assign prod_k = SEED_K * term;
  assign prod_c = SEED_C * term;

  assign old_new = mw_r ^ stir(tbl_rdata);
  assign res_now = fold(tbl_rdata) ^ data_r;
  assign plain   = (act_r == ACT_ENC) ? data_r : res_now;
  assign idx2    = plain + cnt_r[7:0];
  assign fb_word = fwd_r ? new_r : tbl_rdata;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_RESTART) begin
            state_nxt = ST_SCHED_PRE;
          end else if (in_action == ACT_ENC || in_action == ACT_DEC) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_SCHED_PRE: begin
        if (step_r == LAST_PRE) state_nxt = ST_SCHED_FILL;
      end
      ST_SCHED_FILL: begin
        if (step_r == LAST_FILL) state_nxt = ST_OUT;
      end
      ST_READ: state_nxt = ST_MIX;
      ST_MIX: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_OUT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    tbl_rd.en   = 1'b0;
    tbl_rd.addr = fold(mw_r);
    tbl_wr.en   = 1'b0;
    tbl_wr.addr = step_r;
    tbl_wr.data = prod_h ^ stir(h_r);
    ld_restart  = 1'b0;
    ld_item     = 1'b0;
    ld_pre      = 1'b0;
    ld_fill     = 1'b0;
    ld_read     = 1'b0;
    ld_mix      = 1'b0;
    ld_out      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && in_action == ACT_RESTART) begin
          ld_restart = 1'b1;
        end
        if (accept && (in_action == ACT_ENC || in_action == ACT_DEC)) begin
          ld_item   = 1'b1;
          tbl_rd.en = 1'b1;
        end
      end
      ST_SCHED_PRE: ld_pre = 1'b1;
      ST_SCHED_FILL: begin
        ld_fill   = 1'b1;
        tbl_wr.en = 1'b1;
      end
      ST_READ: begin
        ld_read     = 1'b1;
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = pos_r;
        tbl_wr.data = old_new;
        tbl_rd.en   = 1'b1;
        tbl_rd.addr = idx2;
      end
      ST_MIX: begin
        ld_mix = slot_free;
        ld_out = slot_free;
      end
      ST_OUT: ld_out = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    h_nxt    = h_r;
    mw_nxt   = mw_r;
    cnt_nxt  = cnt_r;
    if (ld_restart) begin
      step_nxt = '0;
      h_nxt    = SEED_H;
      mw_nxt   = SEED_K;
      cnt_nxt  = SEED_C;
    end
    if (ld_pre || ld_fill) begin
      step_nxt = step_r + TBL_AW'(1);
      h_nxt    = prod_h ^ stir(h_r);
    end
    if (ld_pre) begin
      // table fill starts again at entry 0
      if (step_r == LAST_PRE) step_nxt = '0;
      mw_nxt  = prod_k ^ stir(mw_r);
      cnt_nxt = prod_c ^ stir(cnt_r);
    end
    if (ld_mix) begin
      mw_nxt  = fb_word ^ stir(mw_r);
      cnt_nxt = cnt_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mw_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mw_r    <= mw_nxt;
      cnt_r   <= cnt_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    h_r    <= h_nxt;
    if (ld_item) begin
      act_r  <= in_action;
      data_r <= in_data_in;
      pos_r  <= fold(mw_r);
    end
    if (ld_read) begin
      res_r <= res_now;
      fwd_r <= (idx2 == pos_r);
      new_r <= old_new;
    end
    if (ld_out) begin
      out_data_r <= (state_r == ST_OUT) ? 8'd0 : res_r;
      out_rd_r   <= (state_r == ST_OUT);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_out     = out_data_r;
  assign out_restart_done = out_rd_r;

endmodule

// ----- rtl/tbsc_checker.sv -----
// ----------------------------------------------------------------------------
// tbsc_checker
// Port-level checks for the byte stream cipher, bound to the top level.
// ----------------------------------------------------------------------------
module tbsc_checker
  import tbsc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_out,
  input logic       out_restart_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data_out) && $stable(out_restart_done))
    else $error("output payload changed while stalled");

  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_restart_done |-> out_data_out == 8'd0)
    else $error("restart result carries nonzero data");

  a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_RESTART |=> !in_ready ##1 !in_ready)
    else $error("input taken during key schedule");

endmodule

bind table_driven_byte_stream_cipher tbsc_checker u_tbsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_data_out    (out_data_out),
  .out_restart_done(out_restart_done)
);

// ----- sim/cipher_checker.sv -----
// ----------------------------------------------------------------------------
// cipher_checker
// Follows the key writes and input beats of the byte stream cipher, keeps its
// own copy of the keys, mixing table, mixing word and counter, and checks
// every output beat against the oldest predicted byte.
// ----------------------------------------------------------------------------
module cipher_checker
  import tbsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_data_out,
  input  logic        out_restart_done,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned results_seen,
  output int unsigned restarts_seen
);

  typedef struct packed {
    logic [7:0] data_out;
    logic       restart_done;
  } cipher_beat_t;

  logic [63:0]  key_reg [KEY_REGS];
  logic [31:0]  mix_tbl [TBL_DEPTH];
  logic [31:0]  mix_acc;
  logic [31:0]  stream_ctr;
  cipher_beat_t due_beats [$];
  cipher_beat_t want;
  logic [7:0]   got;
  int unsigned  bad_count = 0;
  int unsigned  result_count = 0;
  int unsigned  restart_count = 0;

  function automatic logic [31:0] spin(input logic [31:0] x);
    return (x << 2) ^ (x >> 2);
  endfunction

  function automatic logic [7:0] collapse(input logic [31:0] x);
    return x[31:24] ^ x[23:16] ^ x[15:8] ^ x[7:0];
  endfunction

  // signed key byte plus base
  function automatic logic [31:0] key_add(input int unsigned pos, input logic [31:0] base);
    logic [7:0] kb;
    kb = key_reg[pos / 8][8 * (pos % 8) +: 8];
    return base + {{24{kb[7]}}, kb};
  endfunction

  task automatic run_key_schedule();
    logic [31:0] h;
    logic [31:0] t;
    h = SEED_H;
    for (int i = 0; i < KEY_BYTES; i++) h = (MUL_H * key_add(i, 32'(i))) ^ spin(h);
    for (int j = 0; j < TBL_DEPTH; j++) begin
      h = (MUL_H * key_add(j % KEY_BYTES, 32'(j))) ^ spin(h);
      mix_tbl[j] = h;
    end
    mix_acc = SEED_K;
    stream_ctr = SEED_C;
    for (int i = 0; i < KEY_BYTES; i++) begin
      t = key_add(i, 32'(i));
      mix_acc = (SEED_K * t) ^ spin(mix_acc);
      stream_ctr = (SEED_C * t) ^ spin(stream_ctr);
    end
  endtask

  task automatic cipher_byte(input logic [1:0] act, input logic [7:0] d, output logic [7:0] res);
    logic [7:0]  slot;
    logic [7:0]  fb;
    logic [7:0]  fb_slot;
    logic [31:0] old;
    slot = collapse(mix_acc);
    old = mix_tbl[slot];
    mix_tbl[slot] = mix_acc ^ spin(old);
    res = collapse(old) ^ d;
    // plaintext feeds back in both directions
    fb = (act == ACT_ENC) ? d : res;
    fb_slot = fb + stream_ctr[7:0];
    mix_acc = mix_tbl[fb_slot] ^ spin(mix_acc);
    stream_ctr = stream_ctr + 1;
  endtask

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] wanted);
    $display("[%0t] mismatch, %s: got %0h, expected %0h", $time, what, seen, wanted);
    bad_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) key_reg[i] = '0;
      mix_acc = '0;
      stream_ctr = '0;
      due_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (due_beats.size() == 0) begin
          report("output beat with nothing expected", out_data_out, 0);
        end else begin
          want = due_beats.pop_front();
          if (out_data_out !== want.data_out) report("data_out", out_data_out, want.data_out);
          if (out_restart_done !== want.restart_done)
            report("restart_done", out_restart_done, want.restart_done);
        end
      end
      if (cfg_valid && cfg_ready) key_reg[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        case (in_action)
          ACT_RESTART: begin
            run_key_schedule();
            restart_count++;
            due_beats.push_back('{data_out: 8'h00, restart_done: 1'b1});
          end
          ACT_ENC, ACT_DEC: begin
            cipher_byte(in_action, in_data_in, got);
            due_beats.push_back('{data_out: got, restart_done: 1'b0});
          end
          default: ;
        endcase
      end
    end
    mismatches    <= bad_count;
    pending       <= due_beats.size();
    results_seen  <= result_count;
    restarts_seen <= restart_count;
  end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the byte stream cipher with key loads, restarts and encipher and
// decipher beats under random gaps and output stalls, and gives the verdict
// from the failure count of the cipher checker.
// ----------------------------------------------------------------------------
module testbench;
  import tbsc_pkg::*;

  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam int unsigned RUN_LIMIT     = 400000;
  localparam int unsigned PHASE_BEATS   = 50;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned HOLD_AFTER    = 120;
  localparam int unsigned SETTLE        = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_action = ACT_RESTART;
  logic [7:0]  in_data_in = 8'h00;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_data_out;
  logic        out_restart_done;
  logic        cfg_ready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned restarts_seen;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned key_loads = 0;
  bit          long_hold_done = 1'b0;

  table_driven_byte_stream_cipher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_data_in       (in_data_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_out     (out_data_out),
    .out_restart_done (out_restart_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  cipher_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_data_in       (in_data_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_out     (out_data_out),
    .out_restart_done (out_restart_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_seen     (results_seen),
    .restarts_seen    (restarts_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("testbench NOT OK");
    $finish;
  end

  // output side: random stalls, plus one long hold to back up the input
  initial begin
    int unsigned r;
    @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 9) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(5, 40)) @(posedge clk);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [255:0] pick_keys();
    logic [255:0] ks;
    for (int i = 0; i < KEY_REGS; i++) begin
      case ($urandom_range(0, 5))
        0: ks[64*i +: 64] = '0;
        1: ks[64*i +: 64] = '1;
        2: ks[64*i +: 64] = {8{8'h80}};
        3: ks[64*i +: 64] = {8{8'h7F}};
        default: ks[64*i +: 64] = {$urandom, $urandom};
      endcase
    end
    return ks;
  endfunction

  task automatic send_beat(input logic [1:0] act, input logic [7:0] d);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_data_in <= d;
    do @(posedge clk); while (!in_ready);
    if (act != ACT_UNUSED) beats_sent++;
  endtask

  // drain all expected results, then let an ignored beat finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_keys(input logic [255:0] ks);
    for (int i = 0; i < KEY_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= KEY_IW'(i);
      cfg_data  <= ks[64*i +: 64];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    key_loads++;
  endtask

  task automatic random_phase();
    int unsigned n;
    int unsigned r;
    logic [1:0]  act;
    send_beat(ACT_RESTART, pick_byte());
    n = 1;
    while (n < PHASE_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 4) act = ACT_RESTART;
      else if (r < 10) act = ACT_UNUSED;
      else if (r < 55) act = ACT_ENC;
      else act = ACT_DEC;
      send_beat(act, pick_byte());
      if (act != ACT_UNUSED) n++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset key; unused code before the table is ever filled
    send_beat(ACT_UNUSED, 8'hFF);
    send_beat(ACT_RESTART, 8'hA5);
    send_beat(ACT_ENC, 8'h00);
    send_beat(ACT_ENC, 8'hFF);
    send_beat(ACT_DEC, 8'h00);
    send_beat(ACT_DEC, 8'hFF);
    send_beat(ACT_UNUSED, 8'h00);
    send_beat(ACT_ENC, 8'h80);
    send_beat(ACT_DEC, 8'h7F);

    settle();
    load_keys({32{8'hFF}});
    send_beat(ACT_RESTART, 8'h00);
    send_beat(ACT_ENC, 8'h55);
    send_beat(ACT_DEC, 8'hAA);

    settle();
    load_keys({32{8'h80}});
    send_beat(ACT_RESTART, 8'hFF);
    send_beat(ACT_ENC, 8'h01);
    send_beat(ACT_DEC, 8'hFE);

    settle();
    load_keys({32{8'h7F}});
    send_beat(ACT_RESTART, 8'h00);
    send_beat(ACT_RESTART, 8'hFF);
    send_beat(ACT_ENC, 8'h00);
    send_beat(ACT_DEC, 8'hFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      load_keys(pick_keys());
      random_phase();
    end
    settle();

    $display("sent %0d cipher beats over %0d key loads plus the reset key", beats_sent, key_loads);
    $display("checked %0d output beats (%0d restarts), long output hold %0s",
             results_seen, restarts_seen, long_hold_done ? "done" : "not reached");
    if (mismatches == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tbsc_pkg.sv
rtl/tbsc_ram.sv
rtl/tbsc_key.sv
rtl/table_driven_byte_stream_cipher.sv
rtl/tbsc_checker.sv
sim/cipher_checker.sv
sim/testbench.sv
